// ----- hw/rtl/ddo_pkg.sv -----
// Shared types, constants and the arctangent table of the odometry core.
package ddo_pkg;

  localparam int unsigned CordicStepsDef = 16;
  localparam logic [31:0] TurnGainReset  = 32'd2136141486;
  localparam logic [33:0] CordicK        = 34'sd652032874;
  localparam logic [0:0]  RegTurnGain    = 1'b0;

  localparam logic [31:0] AtanTab [32] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
    32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
  };

  typedef struct packed {
    logic load_in;
    logic mul_gain;
    logic load_mid;
    logic rot;
    logic mul_x;
    logic mul_y;
    logic update;
    logic fin;
  } ddo_cmd_t;

  typedef struct packed {
    logic rot_last;
    logic out_free;
  } ddo_stat_t;

endpackage

// ----- hw/rtl/ddo_ctrl.sv -----
// Sequencing state machine of the odometry core.
module ddo_ctrl
  import ddo_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  ddo_stat_t stat_i,
  output ddo_cmd_t  cmd_o
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_MULG = 9'b000000010,
    S_ANG  = 9'b000000100,
    S_ROT  = 9'b000001000,
    S_MULX = 9'b000010000,
    S_MULY = 9'b000100000,
    S_UPD  = 9'b001000000,
    S_ROT2 = 9'b010000000,
    S_FIN  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_MULG;
        end
      end
      S_MULG: begin
        cmd_o.mul_gain = 1'b1;
        state_d        = S_ANG;
      end
      S_ANG: begin
        cmd_o.load_mid = 1'b1;
        state_d        = S_ROT;
      end
      S_ROT: begin
        cmd_o.rot = 1'b1;
        if (stat_i.rot_last) state_d = S_MULX;
      end
      S_MULX: begin
        cmd_o.mul_x = 1'b1;
        state_d     = S_MULY;
      end
      S_MULY: begin
        cmd_o.mul_y = 1'b1;
        state_d     = S_UPD;
      end
      S_UPD: begin
        cmd_o.update = 1'b1;
        state_d      = S_ROT2;
      end
      S_ROT2: begin
        cmd_o.rot = 1'b1;
        if (stat_i.rot_last) state_d = S_FIN;
      end
      S_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.fin = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- hw/rtl/ddo_dpath.sv -----
// Datapath of the odometry core: deltas, shared multiplier, CORDIC and pose.
module ddo_dpath
  import ddo_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = CordicStepsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  ddo_cmd_t     cmd_i,
  output ddo_stat_t    stat_o,
  input  logic [31:0]  turn_gain_i,
  input  logic [31:0]  left_i,
  input  logic [31:0]  right_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [127:0] out_data_o
);

  localparam int unsigned CntW = $clog2(CORDIC_STEPS);

  logic [31:0] prev_l_q, prev_r_q, acc_x_q, acc_y_q, acc_h_q;
  logic signed [31:0] ds_q;
  logic        neg_q, mag_hi_q;
  logic [31:0] mag_lo_q;
  logic signed [64:0] prod_q, prod_d;
  logic [31:0] dth_q;
  logic signed [33:0] cx_q, cy_q, cz_q;
  logic        flip_q;
  logic [CntW-1:0] cnt_q;
  logic        out_valid_q;
  logic [127:0] out_data_q;

  // Deltas from the previous sample.
  logic signed [31:0] dl, dr;
  logic signed [32:0] dsum, diff, amag;
  assign dl   = signed'(left_i - prev_l_q);
  assign dr   = signed'(right_i - prev_r_q);
  assign dsum = 33'(dl) + 33'(dr);
  assign diff = 33'(dr) - 33'(dl);
  assign amag = diff[32] ? -diff : diff;

  // Shared multiplier.
  logic signed [32:0] mul_a;
  logic signed [34:0] mul_b;
  logic signed [67:0] mul_p;
  logic signed [33:0] cos_v, sin_v;
  assign cos_v = flip_q ? -cx_q : cx_q;
  assign sin_v = flip_q ? -cy_q : cy_q;

  always_comb begin
    if (cmd_i.mul_gain) begin
      mul_a = {1'b0, mag_lo_q};
      mul_b = {3'b000, turn_gain_i};
    end else if (cmd_i.mul_x) begin
      mul_a = 33'(ds_q);
      mul_b = 35'(cos_v);
    end else begin
      mul_a = 33'(ds_q);
      mul_b = 35'(sin_v);
    end
  end
  assign mul_p = 68'(mul_a) * 68'(mul_b);

  always_comb begin
    if (cmd_i.mul_gain && mag_hi_q) prod_d = {1'b0, turn_gain_i, 32'h0};
    else                            prod_d = 65'(mul_p);
  end

  // Heading change, low word only.
  logic [64:0] rnd_sum;
  logic [31:0] rnd_lo, dth_d;
  assign rnd_sum = prod_q + 65'h8000;
  assign rnd_lo  = rnd_sum[47:16];
  assign dth_d   = neg_q ? -rnd_lo : rnd_lo;

  // CORDIC load with fold into the right half plane.
  logic [31:0] ang;
  logic signed [33:0] z0, zf;
  logic        fl;
  assign ang = cmd_i.load_mid ? {acc_h_q[30:0], 1'b0} + dth_d : acc_h_q + dth_q;
  assign z0  = 34'(signed'(ang));
  always_comb begin
    zf = z0;
    fl = 1'b0;
    if (z0 > 34'sh40000000) begin
      zf = z0 - 34'sh80000000;
      fl = 1'b1;
    end else if (z0 < -34'sh40000000) begin
      zf = z0 + 34'sh80000000;
      fl = 1'b1;
    end
  end

  logic signed [33:0] xs, ys, at;
  assign xs = cx_q >>> cnt_q;
  assign ys = cy_q >>> cnt_q;
  assign at = 34'(AtanTab[5'(cnt_q)]);

  // Position update with rounding and saturation.
  logic [64:0] psum;
  logic signed [34:0] dpos;
  logic signed [35:0] npos;
  logic [31:0] sat_pos;
  logic [31:0] acc_sel;
  assign psum    = prod_q + 65'h20000000;
  assign dpos    = signed'(psum[64:30]);
  assign acc_sel = cmd_i.mul_y ? acc_x_q : acc_y_q;
  assign npos    = 36'(signed'(acc_sel)) + 36'(dpos);
  always_comb begin
    if (npos > 36'sh7FFFFFFF)       sat_pos = 32'h7FFFFFFF;
    else if (npos < -36'sh80000000) sat_pos = 32'h80000000;
    else                            sat_pos = npos[31:0];
  end

  // Quaternion fields.
  function automatic logic [15:0] quat_f(input logic signed [33:0] v);
    logic signed [33:0] t;
    logic signed [17:0] q;
    t = v + 34'sd32768;
    q = t[33:16];
    if (q > 18'sd16384)       return 16'sd16384;
    else if (q < -18'sd16384) return -16'sd16384;
    else                      return q[15:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_l_q   <= '0;
      prev_r_q   <= '0;
      ds_q       <= '0;
      neg_q      <= 1'b0;
      mag_hi_q   <= 1'b0;
      mag_lo_q   <= '0;
      prod_q     <= '0;
      dth_q      <= '0;
      cx_q       <= '0;
      cy_q       <= '0;
      cz_q       <= '0;
      flip_q     <= 1'b0;
      acc_x_q    <= '0;
      acc_y_q    <= '0;
      acc_h_q    <= '0;
      out_data_q <= '0;
    end else begin
      if (cmd_i.load_in) begin
        prev_l_q <= left_i;
        prev_r_q <= right_i;
        ds_q     <= dsum[32:1];
        neg_q    <= diff[32];
        mag_hi_q <= amag[32];
        mag_lo_q <= amag[31:0];
      end
      if (cmd_i.mul_gain || cmd_i.mul_x || cmd_i.mul_y) prod_q <= prod_d;
      if (cmd_i.load_mid) dth_q <= dth_d;
      if (cmd_i.load_mid || cmd_i.update) begin
        cx_q   <= CordicK;
        cy_q   <= '0;
        cz_q   <= zf;
        flip_q <= fl;
      end else if (cmd_i.rot) begin
        if (!cz_q[33]) begin
          cx_q <= cx_q - ys;
          cy_q <= cy_q + xs;
          cz_q <= cz_q - at;
        end else begin
          cx_q <= cx_q + ys;
          cy_q <= cy_q - xs;
          cz_q <= cz_q + at;
        end
      end
      if (cmd_i.mul_y) acc_x_q <= sat_pos;
      if (cmd_i.update) begin
        acc_y_q <= sat_pos;
        acc_h_q <= acc_h_q + dth_q;
      end
      if (cmd_i.fin) begin
        out_data_q <= {quat_f(cos_v), quat_f(sin_v), acc_h_q, acc_y_q, acc_x_q};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load_mid || cmd_i.update) begin
        cnt_q <= '0;
      end else if (cmd_i.rot) begin
        cnt_q <= (cnt_q == CntW'(CORDIC_STEPS - 1)) ? '0 : cnt_q + 1'b1;
      end
      if (cmd_i.fin)        out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign stat_o.rot_last = (cnt_q == CntW'(CORDIC_STEPS - 1));
  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_data_q;

endmodule

// ----- hw/rtl/diff_drive_odometry_core.sv -----
// Items are processed one at a time: a new item is taken only once the sequencer is
// back in idle, after the two passes of the single iterative CORDIC unit and the
// shared multiplier steps of the last item.
// The result sits in an output register, so the next item is taken while it waits.
// Reset (rst_ni low, asynchronous) clears the pose, the previous wheel travel and
// the sequencer, and loads turn_gain with its default.
module diff_drive_odometry_core
  import ddo_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = CordicStepsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Input item stream.
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [63:0]  s_axis_tdata_i,  // left_travel [31:0], right_travel [63:32]
  // Result item stream.
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [127:0] m_axis_tdata_o,  // pos_x, pos_y, heading, quat_z, quat_w
  // Configuration port.
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  // The only register is turn_gain at address zero; paddr[2] is its index.
  logic [31:0] turn_gain_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegTurnGain);
  assign prdata = (paddr[2] == RegTurnGain) ? turn_gain_q : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      turn_gain_q <= TurnGainReset;
    end else if (cfg_wr) begin
      turn_gain_q <= pwdata;
    end
  end

  ddo_cmd_t  cmd;
  ddo_stat_t stat;

  // The controller walks one item through delta, gain multiply, CORDIC for the
  // mid-step heading, the two position multiplies, the pose update and a second
  // CORDIC pass for the quaternion.
  ddo_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ddo_dpath #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .turn_gain_i (turn_gain_q),
    .left_i      (s_axis_tdata_i[31:0]),
    .right_i     (s_axis_tdata_i[63:32]),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule

// ----- hw/rtl/ddo_checker.sv -----
// Port-level checks of the odometry core and their binding.
module ddo_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid_i,
  input logic         s_axis_tready_o,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [127:0] m_axis_tdata_o
);

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

  // Once an item is taken the block is busy the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("second item taken back to back");

  // No result appears in the cycle right after an accept made while no result was pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && !m_axis_tvalid_o |=> !m_axis_tvalid_o)
    else $error("result too early");

  // Quaternion fields stay within unit range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      ($signed(m_axis_tdata_o[111:96]) <= 16'sd16384) &&
      ($signed(m_axis_tdata_o[111:96]) >= -16'sd16384) &&
      ($signed(m_axis_tdata_o[127:112]) <= 16'sd16384) &&
      ($signed(m_axis_tdata_o[127:112]) >= -16'sd16384))
    else $error("quaternion out of range");

endmodule

bind diff_drive_odometry_core ddo_checker u_chk (.*);
